// ===== hw/rtl/bitblt_word_merge_unit_defines.svh =====
// ----------------------------------------------------------------------------
// bitblt_word_merge_unit_defines.svh
// Assertion macros for the word merge RTL (included by bwm_merge).
// ----------------------------------------------------------------------------
`ifndef BITBLT_WORD_MERGE_UNIT_DEFINES_SVH
`define BITBLT_WORD_MERGE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// expr must hold at every clock edge out of reset
`define BWM_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// cons must hold in the cycle after ante
`define BWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BWM_ASSERT(label, expr, msg)
`define BWM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/bwm_pkg.sv =====
// ----------------------------------------------------------------------------
// bwm_pkg
// Widths, register indexes, row geometry type and helper functions.
// ----------------------------------------------------------------------------
package bwm_pkg;

  localparam int WORD_W         = 32;
  localparam int OFS_W          = $clog2(WORD_W);
  localparam int OFS1_W         = OFS_W + 1;
  localparam int WIDTH_W        = 13;
  localparam int RULE_W         = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = WIDTH_W;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int PIX_W          = $clog2(MAX_ROW_PIXELS + 1);
  localparam int CALC_W         = ((PIX_W > WIDTH_W) ? PIX_W : WIDTH_W) + 1;
  // worst case: one pixel in the first word, rest spread over following words
  localparam int MAX_WORDS      = (MAX_ROW_PIXELS + WORD_W - 2) / WORD_W + 1;
  localparam int WIDX_W         = $clog2(MAX_WORDS);
  localparam int IDX1_W         = WIDX_W + 1;
  localparam int NW_W           = $clog2(MAX_WORDS + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_BIT_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_BIT_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIT_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROP             = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SOURCE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TO_LEFT   = 3'd5;

  // reset values
  localparam logic [OFS_W-1:0]   RST_DEST_BIT_OFFSET = '0;
  localparam logic [OFS_W-1:0]   RST_SRC_BIT_OFFSET  = '0;
  localparam logic [WIDTH_W-1:0] RST_BLIT_WIDTH      = 13'd1;
  localparam logic [RULE_W-1:0]  RST_ROP             = 4'd3;
  localparam logic               RST_USE_SOURCE      = 1'b1;
  localparam logic               RST_RIGHT_TO_LEFT   = 1'b0;

  typedef struct packed {
    logic [WORD_W-1:0] mask_first;
    logic [WORD_W-1:0] mask_last;
    logic [WORD_W-1:0] skew_mask;
    logic [OFS_W-1:0]  skew;
    logic [NW_W-1:0]   nwords;
    logic              preload;
    logic              use_source;
    logic [RULE_W-1:0] rop;
  } geom_t;

  function automatic logic [WORD_W-1:0] low_ones(input logic [OFS1_W-1:0] n);
    logic [WORD_W-1:0] one;
    one = WORD_W'(1);
    return n[OFS_W] ? '1 : ((one << n[OFS_W-1:0]) - one);
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input logic [OFS_W-1:0]  s);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << s;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

  // rule bit 0: S&D, bit 1: S&~D, bit 2: ~S&D, bit 3: ~S&~D (minterm form)
  function automatic logic [WORD_W-1:0] combine(input logic [WORD_W-1:0] s,
                                                input logic [WORD_W-1:0] d,
                                                input logic [RULE_W-1:0] rule);
    return ({WORD_W{rule[0]}} &  s &  d) |
           ({WORD_W{rule[1]}} &  s & ~d) |
           ({WORD_W{rule[2]}} & ~s &  d) |
           ({WORD_W{rule[3]}} & ~s & ~d);
  endfunction

endpackage

// ===== hw/rtl/bwm_in_if.sv =====
// ----------------------------------------------------------------------------
// bwm_in_if
// Input word channel: source, destination and halftone words.
// ----------------------------------------------------------------------------
interface bwm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [bwm_pkg::WORD_W-1:0] source_word;
  logic [bwm_pkg::WORD_W-1:0] dest_word;
  logic [bwm_pkg::WORD_W-1:0] halftone_word;

  modport source (output valid, kind, source_word, dest_word, halftone_word,
                  input ready);
  modport sink   (input valid, kind, source_word, dest_word, halftone_word,
                  output ready);
endinterface

// ===== hw/rtl/bwm_out_if.sv =====
// ----------------------------------------------------------------------------
// bwm_out_if
// Result word channel: merged destination word and row end flag.
// ----------------------------------------------------------------------------
interface bwm_out_if;
  logic                       valid;
  logic                       ready;
  logic [bwm_pkg::WORD_W-1:0] merged_word;
  logic                       last_in_row;

  modport source (output valid, merged_word, last_in_row, input ready);
  modport sink   (input valid, merged_word, last_in_row, output ready);
endinterface

// ===== hw/rtl/bwm_geom.sv =====
// ----------------------------------------------------------------------------
// bwm_geom
// Configuration registers and registered row geometry (masks, skew, words).
// ----------------------------------------------------------------------------
module bwm_geom (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bwm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output bwm_pkg::geom_t                   geom
);

  logic [bwm_pkg::OFS_W-1:0]   dest_ofs_r;
  logic [bwm_pkg::OFS_W-1:0]   src_ofs_r;
  logic [bwm_pkg::WIDTH_W-1:0] width_r;
  logic [bwm_pkg::RULE_W-1:0]  rule_r;
  logic                        use_src_r;
  logic                        rtl_r;
  bwm_pkg::geom_t              geom_r;
  bwm_pkg::geom_t              geom_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_ofs_r <= bwm_pkg::RST_DEST_BIT_OFFSET;
      src_ofs_r  <= bwm_pkg::RST_SRC_BIT_OFFSET;
      width_r    <= bwm_pkg::RST_BLIT_WIDTH;
      rule_r     <= bwm_pkg::RST_ROP;
      use_src_r  <= bwm_pkg::RST_USE_SOURCE;
      rtl_r      <= bwm_pkg::RST_RIGHT_TO_LEFT;
    end else if (cfg_we) begin
      case (cfg_index)
        bwm_pkg::CFG_DEST_BIT_OFFSET: dest_ofs_r <= cfg_wdata[bwm_pkg::OFS_W-1:0];
        bwm_pkg::CFG_SRC_BIT_OFFSET:  src_ofs_r  <= cfg_wdata[bwm_pkg::OFS_W-1:0];
        bwm_pkg::CFG_BLIT_WIDTH:      width_r    <= cfg_wdata[bwm_pkg::WIDTH_W-1:0];
        bwm_pkg::CFG_ROP:             rule_r     <= cfg_wdata[bwm_pkg::RULE_W-1:0];
        bwm_pkg::CFG_USE_SOURCE:      use_src_r  <= cfg_wdata[0];
        bwm_pkg::CFG_RIGHT_TO_LEFT:   rtl_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [bwm_pkg::CALC_W-1:0] w_ext;
  logic [bwm_pkg::CALC_W-1:0] w_sat;
  logic [bwm_pkg::OFS1_W-1:0] start_bits;
  logic [bwm_pkg::CALC_W-1:0] start_ext;
  logic [bwm_pkg::CALC_W-1:0] words_calc;
  logic [bwm_pkg::OFS_W-1:0]  end_bits;
  logic [bwm_pkg::OFS_W-1:0]  skew;
  logic [bwm_pkg::OFS_W-1:0]  src_anchor;
  logic [bwm_pkg::WORD_W-1:0] m_first;
  logic [bwm_pkg::WORD_W-1:0] m_last;
  logic [bwm_pkg::WORD_W-1:0] m_skew;
  logic [bwm_pkg::NW_W-1:0]   nwords;
  logic                       single;
  logic                       need_pre;

  always_comb begin
    w_ext = bwm_pkg::CALC_W'(width_r);
    if (w_ext == '0) begin
      w_sat = bwm_pkg::CALC_W'(1);
    end else if (w_ext > bwm_pkg::CALC_W'(bwm_pkg::MAX_ROW_PIXELS)) begin
      w_sat = bwm_pkg::CALC_W'(bwm_pkg::MAX_ROW_PIXELS);
    end else begin
      w_sat = w_ext;
    end

    skew       = src_ofs_r - dest_ofs_r;
    start_bits = bwm_pkg::OFS1_W'(bwm_pkg::WORD_W) - {1'b0, dest_ofs_r};
    start_ext  = bwm_pkg::CALC_W'(start_bits);
    // offset of last pixel within its word, counted from the lsb side
    end_bits   = bwm_pkg::OFS_W'(bwm_pkg::WORD_W - 1)
               - (dest_ofs_r + w_sat[bwm_pkg::OFS_W-1:0] - bwm_pkg::OFS_W'(1));
    m_first    = bwm_pkg::low_ones(start_bits);
    m_last     = ~bwm_pkg::low_ones({1'b0, end_bits});
    m_skew     = (skew == '0) ? '0
               : bwm_pkg::low_ones(bwm_pkg::OFS1_W'(bwm_pkg::WORD_W) - {1'b0, skew});

    single     = w_sat < start_ext;
    words_calc = ((w_sat - start_ext + bwm_pkg::CALC_W'(bwm_pkg::WORD_W - 1))
                  >> bwm_pkg::OFS_W) + bwm_pkg::CALC_W'(1);
    if (single) begin
      m_first = m_first & m_last;
      m_last  = '0;
      nwords  = bwm_pkg::NW_W'(1);
    end else begin
      nwords  = words_calc[bwm_pkg::NW_W-1:0];
    end

    if (rtl_r) begin
      if (nwords > bwm_pkg::NW_W'(1)) begin
        {m_first, m_last} = {m_last, m_first};
      end
      m_skew = ~m_skew;
    end

    src_anchor = rtl_r ? (src_ofs_r + w_sat[bwm_pkg::OFS_W-1:0] - bwm_pkg::OFS_W'(1))
                       : src_ofs_r;
    need_pre   = (skew != '0) && (skew <= src_anchor);

    geom_nxt.mask_first = m_first;
    geom_nxt.mask_last  = m_last;
    geom_nxt.skew_mask  = m_skew;
    geom_nxt.skew       = skew;
    geom_nxt.nwords     = nwords;
    geom_nxt.preload    = use_src_r && (need_pre ^ rtl_r);
    geom_nxt.use_source = use_src_r;
    geom_nxt.rop        = rule_r;
  end

  // tracks the config registers in the cycle after they change
  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

// ===== hw/rtl/bwm_merge.sv =====
// ----------------------------------------------------------------------------
// bwm_merge
// Input register, funnel rotate / combine / mask datapath, row state and
// result register.
// ----------------------------------------------------------------------------
`include "bitblt_word_merge_unit_defines.svh"

module bwm_merge (
  input  logic            clk,
  input  logic            rst_n,
  bwm_in_if.sink          in_ch,
  bwm_out_if.source       out_ch,
  input  bwm_pkg::geom_t  geom
);

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic                       s1_kind_r;
  logic [bwm_pkg::WORD_W-1:0] s1_src_r;
  logic [bwm_pkg::WORD_W-1:0] s1_dst_r;
  logic [bwm_pkg::WORD_W-1:0] s1_half_r;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [bwm_pkg::WORD_W-1:0] merged_r;
  logic                       last_r;

  logic [bwm_pkg::WIDX_W-1:0] widx_r;
  logic [bwm_pkg::WIDX_W-1:0] widx_nxt;
  logic [bwm_pkg::WORD_W-1:0] prev_src_r;
  logic [bwm_pkg::WORD_W-1:0] prev_src_nxt;

  logic                       in_fire;
  logic                       s1_fire;
  logic                       data_fire;
  logic [bwm_pkg::WORD_W-1:0] mixed;
  logic [bwm_pkg::WORD_W-1:0] s_word;
  logic [bwm_pkg::WORD_W-1:0] mask;
  logic [bwm_pkg::WORD_W-1:0] merged;
  logic [bwm_pkg::IDX1_W-1:0] idx_p1;
  logic                       row_last;

  // preload words never need the result register
  assign s1_fire   = s1_valid_r && (s1_kind_r || !out_valid_r || out_ch.ready);
  assign data_fire = s1_fire && !s1_kind_r;
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    mixed  = (prev_src_r & geom.skew_mask) | (s1_src_r & ~geom.skew_mask);
    s_word = geom.use_source ? (bwm_pkg::rotl(mixed, geom.skew) & s1_half_r) : s1_half_r;

    idx_p1   = {1'b0, widx_r} + bwm_pkg::IDX1_W'(1);
    row_last = idx_p1 >= bwm_pkg::IDX1_W'(geom.nwords);

    if (widx_r == '0) begin
      mask = geom.mask_first;
    end else if (row_last) begin
      mask = geom.mask_last;
    end else begin
      mask = '1;
    end

    merged = (bwm_pkg::combine(s_word, s1_dst_r, geom.rop) & mask)
           | (s1_dst_r & ~mask);
  end

  always_comb begin
    widx_nxt     = widx_r;
    prev_src_nxt = prev_src_r;
    if (s1_fire) begin
      if (s1_kind_r) begin
        if (geom.preload && widx_r == '0) begin
          prev_src_nxt = s1_src_r;
        end
      end else begin
        if (geom.use_source) begin
          prev_src_nxt = s1_src_r;
        end
        if (row_last) begin
          widx_nxt     = '0;
          prev_src_nxt = '0;
        end else begin
          widx_nxt = widx_r + bwm_pkg::WIDX_W'(1);
        end
      end
    end

    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (data_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      widx_r      <= '0;
      prev_src_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      widx_r      <= widx_nxt;
      prev_src_r  <= prev_src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_ch.kind;
      s1_src_r  <= in_ch.source_word;
      s1_dst_r  <= in_ch.dest_word;
      s1_half_r <= in_ch.halftone_word;
    end
    if (data_fire) begin
      merged_r <= merged;
      last_r   <= row_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.merged_word = merged_r;
  assign out_ch.last_in_row = last_r;

  `BWM_ASSERT_NEXT(a_row_end_clears, data_fire && row_last,
                   widx_r == '0 && prev_src_r == '0, "row end did not clear row state")
  `BWM_ASSERT_NEXT(a_index_steps, data_fire && !row_last,
                   widx_r == $past(widx_r) + bwm_pkg::WIDX_W'(1), "word index did not advance")
  `BWM_ASSERT_NEXT(a_preload_keeps_index, s1_fire && s1_kind_r,
                   $stable(widx_r), "preload word moved word index")
  `BWM_ASSERT_NEXT(a_preload_no_result, s1_fire && s1_kind_r && (out_ch.ready || !out_valid_r),
                   !out_valid_r, "preload word produced a result")

endmodule

// ===== hw/rtl/bitblt_word_merge_unit.sv =====
// ----------------------------------------------------------------------------
// bitblt_word_merge_unit
// Bit block transfer row merge: skewed source, halftone, raster op, edge masks.
// ----------------------------------------------------------------------------
// Path: a data word passes the input register, then the merge logic into the
//   result register; while out_ch stalls it waits in the input register.
// Throughput: one word per cycle while out_ch is not stalled, set by the single
//   merge stage; preload words take one slot and give no result.
// Reset (rst_n low, synchronous): config to defaults, row position and held
//   source word cleared, both stages emptied.
module bitblt_word_merge_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bwm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  bwm_in_if.sink                          in_ch,
  bwm_out_if.source                       out_ch
);

  bwm_pkg::geom_t geom;

  bwm_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  bwm_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .geom   (geom)
  );

endmodule
